// ===== rtl/sst_pkg.sv =====
// Package: sizes, codes, types and helpers shared by the schedule table cells and top level.
`timescale 1ns / 1ps
package sst_pkg;

    localparam int TABLE_DEPTH = 8;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int CMP_W       = (CNT_W > 4) ? CNT_W : 4;

    localparam int TIME_W = 17;
    localparam int DUR_W  = 8;
    localparam int POS_W  = 3;
    localparam int OCNT_W = 4;

    localparam logic [3:0] MAX_ENTRIES_RST = 4'd5;

    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_REMOVE = 2'd1;
    localparam logic [1:0] MODE_READ   = 2'd2;

    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_FULL      = 3'd1;
    localparam logic [2:0] ST_REMOVED   = 3'd2;
    localparam logic [2:0] ST_BAD_INDEX = 3'd3;
    localparam logic [2:0] ST_READ      = 3'd4;
    localparam logic [2:0] ST_BAD_TIME  = 3'd5;

    typedef struct packed {
        logic [TIME_W-1:0] tod;
        logic [DUR_W-1:0]  dur;
    } t_entry;

    // per-cell control from the top level
    typedef struct packed {
        logic ins;       // insert transaction goes ahead
        logic rem;       // remove transaction goes ahead
        logic occupied;  // cell holds a live entry
        logic shift;     // cell sits at or above the removed slot
    } t_cell_ctl;

    function automatic logic [POS_W-1:0] idx_to_pos(input logic [IDX_W-1:0] idx);
        logic [IDX_W+POS_W-1:0] wide;
        wide = {{POS_W{1'b0}}, idx};
        return wide[POS_W-1:0];
    endfunction

    function automatic logic [OCNT_W-1:0] cnt_to_out(input logic [CNT_W-1:0] cnt);
        logic [CNT_W+OCNT_W-1:0] wide;
        wide = {{OCNT_W{1'b0}}, cnt};
        return wide[OCNT_W-1:0];
    endfunction

endpackage

// ===== rtl/sst_cell.sv =====
// One table cell: holds an entry, compares against the new one and shifts with its neighbours.
`timescale 1ns / 1ps
module sst_cell (
    input  logic               i_clk,
    input  sst_pkg::t_cell_ctl i_ctl,
    input  sst_pkg::t_entry    i_new,
    input  sst_pkg::t_entry    i_left,
    input  logic               i_left_before,
    input  sst_pkg::t_entry    i_right,
    output sst_pkg::t_entry    o_entry,
    output logic               o_before
);
    import sst_pkg::*;

    t_entry r_entry;
    t_entry n_entry;

    // new entry belongs at or ahead of this cell (an empty cell always qualifies)
    assign o_before = !i_ctl.occupied
                   || (i_new.tod < r_entry.tod)
                   || ((i_new.tod == r_entry.tod) && (i_new.dur > r_entry.dur));

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.ins && o_before) begin
            n_entry = i_left_before ? i_left : i_new;
        end else if (i_ctl.rem && i_ctl.shift) begin
            n_entry = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

// ===== rtl/sorted_schedule_table_unit.sv =====
// Top level: sorted schedule table built as a row of shifting cells with a registered result.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+---------------------------------------------
//  in      | into unit | i_in_valid / o_in_stall | i_mode i_hour_twelve i_minute i_afternoon
//          |           |                         | i_run_seconds i_slot
//  out     | from unit | o_out_valid / i_out_stall| o_status o_position o_entry_count
//          |           |                         | o_entry_time o_entry_duration
//  cfg     | into unit | i_cfg_we (no stall)     | i_cfg_data (max_entries)
//
// For each transaction every cell compares the new entry with its own in parallel and the
// whole row shifts (right for insert, left for remove) on the accept edge. The result lands
// in the output register on that same edge; one transaction per cycle while o_in_stall is low.
// A new transaction is taken while the output register is empty or being drained, so the
// only stall is the output side holding a result (o_in_stall follows it directly).
// Reset (synchronous, active low) empties the table and sets max_entries to 5; entry
// contents are not cleared, only the fill count is.
`timescale 1ns / 1ps
module sorted_schedule_table_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input channel
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_mode,
    input  logic [3:0] i_hour_twelve,
    input  logic [5:0] i_minute,
    input  logic       i_afternoon,
    input  logic [7:0] i_run_seconds,
    input  logic [2:0] i_slot,
    // output channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_status,
    output logic [2:0]  o_position,
    output logic [3:0]  o_entry_count,
    output logic [16:0] o_entry_time,
    output logic [7:0]  o_entry_duration,
    // configuration
    input  logic        i_cfg_we,
    input  logic [3:0]  i_cfg_data
);
    import sst_pkg::*;

    // control state
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [3:0]       r_max_entries;
    logic             r_out_valid;

    // result register (payload, no reset)
    logic [2:0]        r_status,   n_status;
    logic [POS_W-1:0]  r_position, n_position;
    logic [OCNT_W-1:0] r_entry_cnt, n_entry_cnt;
    logic [TIME_W-1:0] r_entry_time, n_entry_time;
    logic [DUR_W-1:0]  r_entry_dur, n_entry_dur;

    logic             accept;
    logic [CMP_W-1:0] count_ext;
    logic [CMP_W-1:0] limit;
    logic [CMP_W-1:0] slot_ext;
    logic             full;
    logic             bad_time;
    logic             slot_ok;
    logic             do_ins;
    logic             do_rem;
    logic [4:0]       hour24;
    logic [TIME_W-1:0] new_tod;
    t_entry           new_entry;
    logic [IDX_W-1:0] ins_idx;
    logic [IDX_W-1:0] rd_idx;
    logic [IDX_W+2:0] slot_wide;

    t_entry           cell_entry [TABLE_DEPTH];
    logic             cell_before[TABLE_DEPTH];
    t_cell_ctl        cell_ctl   [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] ins_here;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign accept     = i_in_valid && !o_in_stall;

    // admission checks
    always_comb begin
        count_ext = CMP_W'(r_count);
        slot_ext  = CMP_W'(i_slot);
        limit     = (CMP_W'(r_max_entries) > CMP_W'(TABLE_DEPTH)) ? CMP_W'(TABLE_DEPTH)
                                                                  : CMP_W'(r_max_entries);
        full      = count_ext >= limit;
        bad_time  = !(i_hour_twelve inside {[4'd1:4'd12]}) || (i_minute > 6'd59);
        slot_ok   = slot_ext < count_ext;
        do_ins    = accept && (i_mode == MODE_INSERT) && !full && !bad_time;
        do_rem    = accept && (i_mode == MODE_REMOVE) && slot_ok;
    end

    // 12-hour clock to seconds since midnight: 12 AM is hour 0, PM adds twelve
    always_comb begin
        hour24 = (i_hour_twelve == 4'd12) ? 5'd0 : {1'b0, i_hour_twelve};
        if (i_afternoon) begin
            hour24 = hour24 + 5'd12;
        end
        new_tod = TIME_W'(hour24 * 17'd3600) + TIME_W'(i_minute * 12'd60);
        new_entry.tod = new_tod;
        new_entry.dur = i_run_seconds;
    end

    // row of cells
    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        assign cell_ctl[g].ins      = do_ins;
        assign cell_ctl[g].rem      = do_rem;
        assign cell_ctl[g].occupied = CMP_W'(g) < count_ext;
        assign cell_ctl[g].shift    = CMP_W'(g) >= slot_ext;

        if (g == 0) begin : g_first
            assign ins_here[g] = cell_before[g];
        end else begin : g_rest
            assign ins_here[g] = cell_before[g] && !cell_before[g-1];
        end

        sst_cell u_cell (
            .i_clk         (i_clk),
            .i_ctl         (cell_ctl[g]),
            .i_new         (new_entry),
            .i_left        ((g == 0) ? new_entry : cell_entry[(g == 0) ? 0 : g-1]),
            .i_left_before ((g == 0) ? 1'b0 : cell_before[(g == 0) ? 0 : g-1]),
            .i_right       (cell_entry[(g == TABLE_DEPTH-1) ? g : g+1]),
            .o_entry       (cell_entry[g]),
            .o_before      (cell_before[g])
        );
    end

    // insert position: the single cell where the before flag first rises
    always_comb begin
        ins_idx = '0;
        for (int k = 0; k < TABLE_DEPTH; k++) begin
            if (ins_here[k]) begin
                ins_idx = ins_idx | IDX_W'(k);
            end
        end
    end

    assign slot_wide = {{IDX_W{1'b0}}, i_slot};
    assign rd_idx    = slot_wide[IDX_W-1:0];

    // result and next count
    always_comb begin
        n_count      = r_count;
        n_status     = ST_BAD_INDEX;
        n_position   = '0;
        n_entry_time = '0;
        n_entry_dur  = '0;
        case (i_mode)
            MODE_INSERT: begin
                if (full) begin
                    n_status = ST_FULL;
                end else if (bad_time) begin
                    n_status = ST_BAD_TIME;
                end else begin
                    n_status     = ST_INSERTED;
                    n_position   = idx_to_pos(ins_idx);
                    n_entry_time = new_tod;
                    n_entry_dur  = i_run_seconds;
                    n_count      = r_count + CNT_W'(1);
                end
            end
            MODE_REMOVE: begin
                n_position = i_slot;
                if (slot_ok) begin
                    n_status = ST_REMOVED;
                    n_count  = r_count - CNT_W'(1);
                end
            end
            MODE_READ: begin
                n_position = i_slot;
                if (slot_ok) begin
                    n_status     = ST_READ;
                    n_entry_time = cell_entry[rd_idx].tod;
                    n_entry_dur  = cell_entry[rd_idx].dur;
                end
            end
            default: begin
                n_status = ST_BAD_INDEX;
            end
        endcase
        n_entry_cnt = cnt_to_out(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count       <= '0;
            r_max_entries <= MAX_ENTRIES_RST;
            r_out_valid   <= 1'b0;
        end else begin
            if (accept) begin
                r_count <= n_count;
            end
            if (i_cfg_we) begin
                r_max_entries <= i_cfg_data;
            end
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status     <= n_status;
            r_position   <= n_position;
            r_entry_cnt  <= n_entry_cnt;
            r_entry_time <= n_entry_time;
            r_entry_dur  <= n_entry_dur;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_status;
    assign o_position       = r_position;
    assign o_entry_count    = r_entry_cnt;
    assign o_entry_time     = r_entry_time;
    assign o_entry_duration = r_entry_dur;

    // fill count never passes the table depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CMP_W'(r_count) <= CMP_W'(TABLE_DEPTH))
        else $error("fill count beyond table depth");

    // exactly one cell claims the insert
    a_ins_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_ins |-> $onehot(ins_here))
        else $error("insert position not unique");

    // insert grows the table by one
    a_ins_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_ins |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("insert did not bump fill count");

    // remove shrinks the table by one and reports it
    a_rem_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_rem |=> (r_count == $past(r_count) - CNT_W'(1)) && o_out_valid
                   && (o_status == ST_REMOVED))
        else $error("remove bookkeeping wrong");

    // a stalled result blocks new transactions
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |-> !accept)
        else $error("transaction taken over a held result");

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the sorted schedule table: queued stimulus, prediction, checks.
`timescale 1ns / 1ps
module testbench;
    import sst_pkg::*;

    // mode 3 has no name in the package; the block answers it as a bad index
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int HOLD_CYCLES = 80;    // long receiver hold-off for the back-pressure phase
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_OPS = 110;

    typedef struct packed {
        logic [1:0] mode;
        logic [3:0] hour;
        logic [5:0] minute;
        logic       pm;
        logic [7:0] dur;
        logic [2:0] slot;
    } t_sched_op;

    typedef struct packed {
        logic [2:0]        status;
        logic [POS_W-1:0]  pos;
        logic [OCNT_W-1:0] count;
        logic [TIME_W-1:0] tod;
        logic [DUR_W-1:0]  dur;
    } t_sched_result;

    // ---------------------------------------------------------------------------------------
    // Block connections; every input starts at a known value
    // ---------------------------------------------------------------------------------------
    logic              i_clk;
    logic              i_rst_n     = 1'b0;
    logic              i_in_valid  = 1'b0;
    logic              o_in_stall;
    t_sched_op         op_drv      = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    logic [2:0]        o_status;
    logic [2:0]        o_position;
    logic [3:0]        o_entry_count;
    logic [16:0]       o_entry_time;
    logic [7:0]        o_entry_duration;
    logic              i_cfg_we    = 1'b0;
    logic [3:0]        i_cfg_data  = MAX_ENTRIES_RST;

    sorted_schedule_table_unit uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_mode           (op_drv.mode),
        .i_hour_twelve    (op_drv.hour),
        .i_minute         (op_drv.minute),
        .i_afternoon      (op_drv.pm),
        .i_run_seconds    (op_drv.dur),
        .i_slot           (op_drv.slot),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_status         (o_status),
        .o_position       (o_position),
        .o_entry_count    (o_entry_count),
        .o_entry_time     (o_entry_time),
        .o_entry_duration (o_entry_duration),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data)
    );

    // ---------------------------------------------------------------------------------------
    // Shared testbench state
    // ---------------------------------------------------------------------------------------
    t_sched_op     op_backlog [$];      // transactions waiting for the driver
    t_sched_result expected_q [$];      // predicted results, oldest first

    // predictor's own copy of the table and the limit register
    logic [TIME_W-1:0] sched_tod [TABLE_DEPTH];
    logic [DUR_W-1:0]  sched_len [TABLE_DEPTH];
    int                sched_fill;
    logic [3:0]        fill_cap = MAX_ENTRIES_RST;

    bit tx_quiet = 1'b0;                // when set, the sender offers back to back
    bit rx_quiet = 1'b0;                // when set, the receiver never stalls on its own
    int hold_tok = 0;                   // bumped to ask the receiver for a long hold-off
    int hold_seen = 0;
    int tx_wait = 0;
    int rx_wait = 0;

    int ops_done = 0;
    int results_seen = 0;
    int fault_count = 0;
    int status_seen [8];
    int caps_used = 0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------------------------------
    // Predictor: applies one transaction to the shadow table and returns the expected result
    // ---------------------------------------------------------------------------------------
    function automatic t_sched_result table_update(input t_sched_op op);
        t_sched_result r;
        int limit, h24, tod, at, i;
        bit placed;
        r = '0;
        limit = (fill_cap > TABLE_DEPTH) ? TABLE_DEPTH : int'(fill_cap);
        case (op.mode)
            MODE_INSERT: begin
                // the full check wins over a malformed time
                if (sched_fill >= limit) begin
                    r.status = ST_FULL;
                end else if (op.hour < 1 || op.hour > 12 || op.minute > 59) begin
                    r.status = ST_BAD_TIME;
                end else begin
                    h24 = (op.hour == 12) ? 0 : int'(op.hour);   // 12 AM is midnight
                    if (op.pm)
                        h24 += 12;
                    tod = h24 * 3600 + int'(op.minute) * 60;
                    // earlier time first; on a tie the longer run first; full tie goes after
                    at = 0;
                    placed = 1'b0;
                    while (at < sched_fill && !placed) begin
                        if (tod < int'(sched_tod[at]) ||
                            (tod == int'(sched_tod[at]) && op.dur > sched_len[at]))
                            placed = 1'b1;
                        else
                            at++;
                    end
                    for (i = sched_fill; i > at; i--) begin
                        sched_tod[i] = sched_tod[i-1];
                        sched_len[i] = sched_len[i-1];
                    end
                    sched_tod[at] = TIME_W'(tod);
                    sched_len[at] = op.dur;
                    sched_fill++;
                    r.status = ST_INSERTED;
                    r.pos    = POS_W'(at);
                    r.tod    = TIME_W'(tod);
                    r.dur    = op.dur;
                end
            end
            MODE_REMOVE: begin
                r.pos = op.slot;
                if (op.slot >= sched_fill) begin
                    r.status = ST_BAD_INDEX;
                end else begin
                    for (i = op.slot; i + 1 < sched_fill; i++) begin
                        sched_tod[i] = sched_tod[i+1];
                        sched_len[i] = sched_len[i+1];
                    end
                    sched_fill--;
                    r.status = ST_REMOVED;
                end
            end
            MODE_READ: begin
                r.pos = op.slot;
                if (op.slot >= sched_fill) begin
                    r.status = ST_BAD_INDEX;
                end else begin
                    r.status = ST_READ;
                    r.tod    = sched_tod[op.slot];
                    r.dur    = sched_len[op.slot];
                end
            end
            default: r.status = ST_BAD_INDEX;   // unused mode: nothing changes, position 0
        endcase
        r.count = OCNT_W'(sched_fill);
        return r;
    endfunction

    // ---------------------------------------------------------------------------------------
    // Driver: feeds the backlog into the input channel with a random gap per transaction
    // ---------------------------------------------------------------------------------------
    always @(posedge i_clk) begin
        bit busy;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            tx_wait = 0;
            sched_fill = 0;
        end else begin
            busy = i_in_valid;
            if (i_in_valid && !o_in_stall) begin
                expected_q = {expected_q, table_update(op_drv)};
                ops_done++;
                tx_wait = tx_quiet ? 0 : $urandom_range(0, 9);
                busy = 1'b0;
            end
            // a stalled transaction keeps valid and payload untouched
            if (!busy) begin
                if (tx_wait > 0) begin
                    tx_wait--;
                    i_in_valid <= 1'b0;
                end else if (op_backlog.size() != 0) begin
                    op_drv     <= op_backlog.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------------------------------
    // Receiver: random stall after each result, plus a long hold-off on request
    // ---------------------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            rx_wait = 0;
        end else if (hold_tok != hold_seen) begin
            hold_seen = hold_tok;
            rx_wait = HOLD_CYCLES;
            i_out_stall <= 1'b1;
        end else if (rx_wait > 0) begin
            rx_wait--;
            i_out_stall <= (rx_wait > 0);
        end else if (o_out_valid && !i_out_stall) begin
            rx_wait = rx_quiet ? 0 : $urandom_range(0, 9);
            i_out_stall <= (rx_wait > 0);
        end
    end

    // ---------------------------------------------------------------------------------------
    // Monitor: every completed result against the oldest prediction, field by field
    // ---------------------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_sched_result got, want;
        bit bad;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = {o_status, o_position, o_entry_count, o_entry_time, o_entry_duration};
            results_seen++;
            if (got.status < 8)
                status_seen[got.status]++;
            if (expected_q.size() == 0) begin
                fault_count++;
                if (fault_count <= 10)
                    $display("%0t: result with nothing outstanding: status %0d position %0d",
                             $realtime, got.status, got.pos);
            end else begin
                want = expected_q.pop_front();
                bad = (got.status !== want.status) || (got.pos !== want.pos) ||
                      (got.count !== want.count) || (got.tod !== want.tod) ||
                      (got.dur !== want.dur);
                if (bad) begin
                    fault_count++;
                    if (fault_count <= 10) begin
                        $display("%0t: result %0d differs (expected/actual):",
                                 $realtime, results_seen);
                        $display("  status %0d/%0d position %0d/%0d count %0d/%0d",
                                 want.status, got.status, want.pos, got.pos,
                                 want.count, got.count);
                        $display("  time %0d/%0d duration %0d/%0d",
                                 want.tod, got.tod, want.dur, got.dur);
                    end
                end
            end
        end
    end

    // ---------------------------------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------------------------------
    function automatic void queue_sched(input logic [1:0] mode, input int hour, input int minute,
                                        input bit pm, input int dur, input int slot);
        t_sched_op op;
        op.mode   = mode;
        op.hour   = 4'(hour);
        op.minute = 6'(minute);
        op.pm     = pm;
        op.dur    = 8'(dur);
        op.slot   = 3'(slot);
        op_backlog = {op_backlog, op};
    endfunction

    function automatic t_sched_op random_op(input int ins_pct);
        t_sched_op op;
        int roll;
        // fields that a mode ignores still toggle every bit
        op.hour   = 4'($urandom);
        op.minute = 6'($urandom);
        op.pm     = 1'($urandom);
        op.dur    = 8'($urandom);
        op.slot   = 3'($urandom);
        roll = $urandom_range(0, 99);
        if (roll < ins_pct)
            op.mode = MODE_INSERT;
        else if (roll >= 95)
            op.mode = MODE_UNUSED;
        else
            op.mode = roll[0] ? MODE_REMOVE : MODE_READ;
        if (op.mode == MODE_INSERT) begin
            op.hour   = 4'($urandom_range(1, 12));
            op.minute = 6'($urandom_range(0, 59));
            roll = $urandom_range(0, 99);
            if (roll < 30) begin
                // crowd onto a few times and runs so ties on both keys turn up
                op.hour   = ($urandom_range(0, 1) != 0) ? 4'd12 : 4'd7;
                op.minute = ($urandom_range(0, 1) != 0) ? 6'd0 : 6'd45;
                op.dur    = 8'($urandom_range(0, 2) * 100);
            end else if (roll < 40) begin
                if ($urandom_range(0, 1) != 0)
                    op.hour = ($urandom_range(0, 3) == 0) ? 4'd0 : 4'($urandom_range(13, 15));
                else
                    op.minute = 6'($urandom_range(60, 63));
            end
        end
        return op;
    endfunction

    // idle: nothing queued, nothing offered, nothing outstanding, then a short margin
    task automatic wait_table_idle();
        do
            @(posedge i_clk);
        while (op_backlog.size() != 0 || i_in_valid || expected_q.size() != 0);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_cap(input logic [3:0] value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        fill_cap = value;
        caps_used++;
    endtask

    // ---------------------------------------------------------------------------------------
    // Sequence: directed checks at the reset limit and at full depth, then random phases
    // ---------------------------------------------------------------------------------------
    initial begin
        int ph, n, ins_pct;
        logic [3:0] cap_v;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty table at the reset limit of five
        queue_sched(MODE_READ,   0, 0, 0, 0, 0);      // read of an empty table
        queue_sched(MODE_REMOVE, 0, 0, 0, 0, 7);      // remove at the top slot, nothing held
        queue_sched(MODE_UNUSED, 0, 0, 0, 0, 5);      // unused mode
        queue_sched(MODE_INSERT, 12, 0, 0, 0, 0);     // midnight, zero run
        queue_sched(MODE_INSERT, 11, 59, 1, 255, 0);  // last minute of the day, longest run
        queue_sched(MODE_INSERT, 12, 0, 1, 10, 0);    // noon
        queue_sched(MODE_INSERT, 12, 0, 1, 20, 0);    // noon, longer run goes first
        queue_sched(MODE_INSERT, 12, 0, 1, 20, 0);    // identical entry goes after
        queue_sched(MODE_INSERT, 1, 0, 0, 5, 0);      // limit reached
        queue_sched(MODE_INSERT, 0, 0, 0, 5, 0);      // full beats bad time
        queue_sched(MODE_REMOVE, 0, 0, 0, 0, 4);      // drop the last entry
        queue_sched(MODE_INSERT, 0, 0, 0, 1, 0);      // hour zero
        queue_sched(MODE_INSERT, 13, 0, 0, 1, 0);     // hour past twelve
        queue_sched(MODE_INSERT, 15, 63, 1, 255, 7);  // every time bit set
        queue_sched(MODE_INSERT, 1, 60, 0, 1, 0);     // minute past 59
        queue_sched(MODE_READ,   0, 0, 0, 0, 0);
        queue_sched(MODE_READ,   0, 0, 0, 0, 3);
        queue_sched(MODE_READ,   0, 0, 0, 0, 4);      // one past the fill
        wait_table_idle();

        // raise the limit to full depth and fill the table to the brim
        write_cap(4'd8);
        queue_sched(MODE_INSERT, 1, 30, 0, 1, 0);
        queue_sched(MODE_INSERT, 12, 59, 1, 128, 0);
        queue_sched(MODE_INSERT, 11, 0, 1, 3, 0);
        queue_sched(MODE_INSERT, 6, 15, 0, 255, 0);
        queue_sched(MODE_INSERT, 2, 0, 0, 2, 0);      // table full at depth
        queue_sched(MODE_READ,   0, 0, 0, 0, 7);
        queue_sched(MODE_REMOVE, 0, 0, 0, 0, 7);
        wait_table_idle();

        // random phases: each sets a limit, an insert bias and how busy each side is
        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph)
                0:       begin cap_v = 4'd8;  ins_pct = 50; end
                1:       begin cap_v = 4'd1;  ins_pct = 40; end
                2:       begin cap_v = 4'd0;  ins_pct = 30; end   // rejects every insert
                3:       begin cap_v = 4'd15; ins_pct = 60; end   // above depth, depth rules
                4:       begin cap_v = 4'd3;  ins_pct = 35; end
                5:       begin cap_v = 4'd8;  ins_pct = 55; end
                6:       begin cap_v = 4'($urandom_range(1, 7)); ins_pct = 25; end
                default: begin cap_v = 4'd8;  ins_pct = 20; end   // mostly draining
            endcase
            write_cap(cap_v);
            tx_quiet = (ph == 1 || ph == 5);
            rx_quiet = (ph == 1);
            for (n = 0; n < PHASE_OPS; n++)
                op_backlog = {op_backlog, random_op(ins_pct)};
            // back-pressure: the receiver holds off while the sender keeps offering
            if (ph == 5) begin
                repeat (4) @(posedge i_clk);
                hold_tok <= hold_tok + 1;
            end
            wait_table_idle();
        end

        $display("Ran %0d transactions under %0d limit settings; %0d inserted, %0d full,",
                 ops_done, caps_used + 1, status_seen[ST_INSERTED], status_seen[ST_FULL]);
        $display("%0d bad time, %0d removed, %0d read, %0d bad index; %0d checked, %0d differing",
                 status_seen[ST_BAD_TIME], status_seen[ST_REMOVED], status_seen[ST_READ],
                 status_seen[ST_BAD_INDEX], results_seen, fault_count);
        if (fault_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // watchdog: far beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("Timed out with %0d transactions and %0d results outstanding",
                 op_backlog.size(), expected_q.size());
        $display("Mismatches found");
        $finish;
    end

endmodule

// ===== sorted_schedule_table_unit.f =====
rtl/sst_pkg.sv
rtl/sst_cell.sv
rtl/sorted_schedule_table_unit.sv
dv/testbench.sv
